FILE: rtl/assert_macros.svh
// assertion macros shared by the sorted queue rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SDQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent that must hold in the clock after the antecedent
`define SDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sdq_pkg.sv
// shared types, codes and helpers for the sorted double-ended queue
// no dependencies
package sdq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [FUNC_W-1:0]         func_t;
  typedef logic [STATUS_W-1:0]       status_t;

  // operation codes
  localparam func_t FUNC_INSERT  = 2'd0;
  localparam func_t FUNC_REM_MIN = 2'd1;
  localparam func_t FUNC_REM_MAX = 2'd2;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rm_min;
    logic rm_max;
  } sdq_ctl_t;

  // signed greater-than
  function automatic logic sdq_gt(input value_t a, input value_t b);
    return a > b;
  endfunction

endpackage

FILE: rtl/sdq_in_if.sv
// input channel of the sorted queue: operation and value words
// depends on sdq_pkg
interface sdq_in_if;
  logic               valid;
  logic               ready;
  sdq_pkg::func_t     func;
  sdq_pkg::value_t    value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

FILE: rtl/sdq_out_if.sv
// output channel of the sorted queue: result value and status words
// depends on sdq_pkg
interface sdq_out_if;
  logic               valid;
  logic               ready;
  sdq_pkg::value_t    result_value;
  sdq_pkg::status_t   status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

FILE: rtl/sdq_cell.sv
// one cell of the sorted row: holds a value and an occupancy flag
// depends on sdq_pkg; neighbours exchange values on insert and on remove-smallest
module sdq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdq_pkg::sdq_ctl_t ctl_i,
  input  sdq_pkg::value_t   ins_value_i,
  input  sdq_pkg::value_t   prev_value_i,
  input  logic              prev_occ_i,
  input  logic              prev_gt_i,
  input  sdq_pkg::value_t   next_value_i,
  input  logic              next_occ_i,
  output sdq_pkg::value_t   value_o,
  output logic              occ_o,
  output logic              gt_o
);

  sdq_pkg::value_t value_q, value_d;
  logic            occ_q, occ_d;

  // held value is larger than the one being inserted
  assign gt_o = occ_q && sdq_pkg::sdq_gt(value_q, ins_value_i);

  // next value: shift up on insert, shift down on remove-smallest; remove-largest frees the highest occupied cell
  always_comb begin
    value_d = value_q;
    occ_d   = occ_q;
    if (ctl_i.ins) begin
      if (prev_gt_i) begin
        value_d = prev_value_i;
        occ_d   = prev_occ_i;
      end else if (gt_o || (!occ_q && prev_occ_i)) begin
        value_d = ins_value_i;
        occ_d   = 1'b1;
      end
    end else if (ctl_i.rm_min) begin
      value_d = next_value_i;
      occ_d   = next_occ_i;
    end else if (ctl_i.rm_max) begin
      occ_d   = occ_q && next_occ_i;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // held value, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign occ_o   = occ_q;

endmodule

FILE: rtl/sorted_double_ended_queue.sv
// sorted double-ended queue: a row of CAPACITY cells kept in ascending order
// each accepted word's result is loaded into the output register
// one word per cycle unless output stalls; all cells update on the same edge
// reset: asynchronous, clears the occupancy flags and the output valid
// stored values are not reset and are only read while occupied
module sorted_double_ended_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdq_in_if.sink     in_i,
  sdq_out_if.source  out_o
);

  `include "assert_macros.svh"

  localparam int unsigned CAP = sdq_pkg::CAPACITY;

  sdq_pkg::value_t   cell_value [CAP];
  logic [CAP-1:0]    cell_occ;
  logic [CAP-1:0]    cell_gt;
  logic [CAP-1:0]    occ_above;
  logic [CAP-1:0]    is_last;

  sdq_pkg::sdq_ctl_t ctl;
  logic              in_acc;
  logic              full;
  logic              empty;

  logic              out_valid_q;
  sdq_pkg::value_t   out_value_q, out_value_d;
  sdq_pkg::status_t  out_status_q, out_status_d;
  sdq_pkg::value_t   max_value;

  // output register frees up when its word is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign full  = cell_occ[CAP-1];
  assign empty = !cell_occ[0];

  // command to the cell row
  always_comb begin
    ctl.ins    = in_acc && (in_i.func == sdq_pkg::FUNC_INSERT)  && !full;
    ctl.rm_min = in_acc && (in_i.func == sdq_pkg::FUNC_REM_MIN) && !empty;
    ctl.rm_max = in_acc && (in_i.func == sdq_pkg::FUNC_REM_MAX) && !empty;
  end

  // row of cells
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    sdq_pkg::value_t prev_value, next_value;
    logic            prev_occ, prev_gt, next_occ;

    if (i == 0) begin : g_first
      assign prev_value = '0;
      assign prev_occ   = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_value = cell_value[i-1];
      assign prev_occ   = cell_occ[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == CAP - 1) begin : g_end
      assign next_value = '0;
      assign next_occ   = 1'b0;
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_occ   = cell_occ[i+1];
    end

    sdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .ins_value_i  (in_i.value),
      .prev_value_i (prev_value),
      .prev_occ_i   (prev_occ),
      .prev_gt_i    (prev_gt),
      .next_value_i (next_value),
      .next_occ_i   (next_occ),
      .value_o      (cell_value[i]),
      .occ_o        (cell_occ[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // pick the highest occupied cell
  assign occ_above = {1'b0, cell_occ[CAP-1:1]};
  assign is_last   = cell_occ & ~occ_above;

  always_comb begin
    max_value = '0;
    for (int unsigned i = 0; i < CAP; i++) begin
      max_value = max_value | (is_last[i] ? cell_value[i] : '0);
    end
  end

  // result word
  always_comb begin
    out_value_d  = '0;
    out_status_d = sdq_pkg::ST_OK;
    case (in_i.func)
      sdq_pkg::FUNC_INSERT: begin
        if (full) begin
          out_status_d = sdq_pkg::ST_FULL;
        end else begin
          out_value_d = in_i.value;
        end
      end
      sdq_pkg::FUNC_REM_MIN: begin
        if (empty) begin
          out_status_d = sdq_pkg::ST_EMPTY;
        end else begin
          out_value_d = cell_value[0];
        end
      end
      sdq_pkg::FUNC_REM_MAX: begin
        if (empty) begin
          out_status_d = sdq_pkg::ST_EMPTY;
        end else begin
          out_value_d = max_value;
        end
      end
      default: begin
        out_value_d  = '0;
        out_status_d = sdq_pkg::ST_OK;
      end
    endcase
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_value_q;
  assign out_o.status       = out_status_q;

  // occupied cells always form a run from the bottom of the row
  `SDQ_ASSERT(a_occ_thermo, clk_i, rst_ni,
    (cell_occ & (cell_occ + CAP'(1))) == '0, "occupancy not contiguous")

  // a successful insert adds exactly one entry
  `SDQ_ASSERT_NEXT(a_ins_count, clk_i, rst_ni, ctl.ins,
    $countones(cell_occ) == $countones($past(cell_occ)) + 1, "insert count wrong")

  // a successful removal drops exactly one entry
  `SDQ_ASSERT_NEXT(a_rm_count, clk_i, rst_ni, ctl.rm_min || ctl.rm_max,
    $countones(cell_occ) + 1 == $countones($past(cell_occ)), "removal count wrong")

  // insert into a full row reports full and leaves the row alone
  `SDQ_ASSERT_NEXT(a_full_status, clk_i, rst_ni,
    in_acc && (in_i.func == sdq_pkg::FUNC_INSERT) && full,
    (out_status_q == sdq_pkg::ST_FULL) && $stable(cell_occ), "full insert mishandled")

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// testbench for the sorted double-ended queue: directed and random words are
// checked against a sorted list kept inside the bench
// depends on sdq_pkg, sdq_in_if, sdq_out_if and sorted_double_ended_queue
module tb;
  import sdq_pkg::*;

  // selector value the block must ignore
  localparam func_t FUNC_UNUSED = 2'd3;

  localparam int unsigned RANDOM_WORDS = 1400;
  localparam int unsigned STALL_A      = 400;
  localparam int unsigned STALL_B      = 1000;
  localparam int unsigned STALL_LEN    = 120;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 100;

  typedef struct {
    func_t       func;
    value_t      value;
    int unsigned gap;
    bit          drain;
  } sdq_word_t;

  typedef struct packed {
    value_t  value;
    status_t status;
  } sdq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sdq_in_if  in_if ();
  sdq_out_if out_if ();

  sorted_double_ended_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sdq_word_t   pending_words[$];
  sdq_result_t expected_results[$];
  value_t      sorted_model[$];

  int unsigned words_in     = 0;
  int unsigned words_out    = 0;
  int unsigned total_words  = 0;
  int unsigned send_wait    = 0;
  int unsigned recv_wait    = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count    = 0;

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string what);
    if (err_count < MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  // sorted list update and the result it gives
  function automatic sdq_result_t predict_result(input func_t f, input value_t v);
    sdq_result_t r;
    int unsigned i;
    r.value  = '0;
    r.status = ST_OK;
    case (f)
      FUNC_INSERT: begin
        if (sorted_model.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // equal values keep arrival order
          i = 0;
          while (i < sorted_model.size() && sorted_model[i] <= v) i++;
          sorted_model.insert(i, v);
          r.value = v;
        end
      end
      FUNC_REM_MIN: begin
        if (sorted_model.size() == 0) r.status = ST_EMPTY;
        else r.value = sorted_model.pop_front();
      end
      FUNC_REM_MAX: begin
        if (sorted_model.size() == 0) r.status = ST_EMPTY;
        else r.value = sorted_model.pop_back();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // values biased towards the extremes and small clustered numbers
  function automatic value_t draw_value();
    case ($urandom_range(0, 9))
      0: return value_t'(32'h7fff_ffff);
      1: return value_t'(32'h8000_0000);
      2, 3, 4: return value_t'(int'($urandom_range(0, 16)) - 8);
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic queue_word(input func_t f, input value_t v, input int unsigned g,
                            input bit d);
    pending_words.push_back('{f, v, g, d});
  endtask

  // input driver: waits out each word's gap, holds a drain word until settled
  always @(posedge clk_i) begin
    sdq_word_t w;
    bit took;
    if (rst_ni) begin
      took = in_if.valid && in_if.ready;
      if (took) begin
        expected_results.push_back(predict_result(in_if.func, in_if.value));
        words_in <= words_in + 1;
        if (pending_words.size() != 0) send_wait = pending_words[0].gap;
      end
      if (!in_if.valid || took) begin
        if (send_wait != 0) begin
          send_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     (!pending_words[0].drain || (!took && words_in == words_out))) begin
          w = pending_words.pop_front();
          in_if.valid <= 1'b1;
          in_if.func  <= w.func;
          in_if.value <= w.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off after chosen input words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (in_if.valid && in_if.ready &&
                   (words_in == STALL_A || words_in == STALL_B)) begin
        stall_left <= STALL_LEN;
      end
    end
  end

  // result monitor and output ready
  always @(posedge clk_i) begin
    sdq_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        words_out <= words_out + 1;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected word value %0d status %0d",
                                  out_if.result_value, out_if.status));
        end else begin
          want = expected_results.pop_front();
          if (out_if.result_value !== want.value)
            note_mismatch($sformatf("word %0d value %0d, wanted %0d", words_out,
                                    out_if.result_value, want.value));
          if (out_if.status !== want.status)
            note_mismatch($sformatf("word %0d status %0d, wanted %0d", words_out,
                                    out_if.status, want.status));
        end
        // every fourth stretch of results runs without gaps
        recv_wait = ((words_out / 128) % 4 == 1) ? 0 : $urandom_range(0, 7);
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("sorted_double_ended_queue test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned last;
    int unsigned len;
    int unsigned thr;
    int unsigned r;
    int unsigned g;
    bit quiet;
    func_t f;

    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.func    = FUNC_INSERT;
    in_if.value   = '0;
    out_if.ready  = 1'b0;

    // removals from an empty store and the unused selector
    queue_word(FUNC_REM_MIN, value_t'($urandom), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_REM_MAX, value_t'($urandom), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_UNUSED, value_t'($urandom), $urandom_range(0, 7), 1'b0);
    // fill to capacity with extremes and duplicates
    queue_word(FUNC_INSERT, value_t'(32'h7fff_ffff), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_INSERT, value_t'(32'h8000_0000), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_INSERT, value_t'(0), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_INSERT, value_t'(-1), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_INSERT, value_t'(1), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_INSERT, value_t'(5), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_INSERT, value_t'(5), $urandom_range(0, 7), 1'b0);
    for (int unsigned i = 7; i < CAPACITY; i++)
      queue_word(FUNC_INSERT, draw_value(), $urandom_range(0, 7), 1'b0);
    // insert into a full store, unused selector while full, both removals
    queue_word(FUNC_INSERT, draw_value(), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_UNUSED, value_t'($urandom), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_REM_MIN, value_t'($urandom), $urandom_range(0, 7), 1'b0);
    queue_word(FUNC_REM_MAX, value_t'($urandom), $urandom_range(0, 7), 1'b0);

    // random bursts leaning to filling, draining or balanced traffic
    n    = pending_words.size();
    last = n + RANDOM_WORDS;
    while (n < last) begin
      case ($urandom_range(0, 2))
        0: thr = 75;
        1: thr = 25;
        default: thr = 50;
      endcase
      len = $urandom_range(20, 60);
      for (int unsigned k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) f = FUNC_UNUSED;
        else if (r < thr) f = FUNC_INSERT;
        else f = $urandom_range(0, 1) ? FUNC_REM_MIN : FUNC_REM_MAX;
        quiet = ((n / 150) % 4 == 3) ||
                (n + 5 >= STALL_A && n < STALL_A + 40) ||
                (n + 5 >= STALL_B && n < STALL_B + 40);
        g = quiet ? 0 : $urandom_range(0, 7);
        queue_word(f, (f == FUNC_INSERT) ? draw_value() : value_t'($urandom), g,
                   n % 300 == 150);
        n++;
      end
    end
    total_words = pending_words.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_in != total_words || words_out != total_words) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (err_count == 0) begin
      $display("sorted_double_ended_queue test passed");
    end else begin
      $display("sorted_double_ended_queue test failed");
    end
    $finish;
  end

endmodule
